// ===== sv/clock_page_replacer_defines.svh =====
// Assertion macros for the clock page replacer.
`ifndef CLOCK_PAGE_REPLACER_DEFINES_SVH
`define CLOCK_PAGE_REPLACER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cpr_pkg.sv =====
// Shared constants and types of the clock page replacer.
package cpr_pkg;

    localparam int SLOTS   = 16;
    localparam int FRAMES  = 16;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int FRAME_W = 4;
    localparam int CNT_W   = 5;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_VICTIM = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PIN    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNPIN  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FRAME_W-1:0] frame_num;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] victim_frame;
        logic [CNT_W-1:0]   tracked_count;
    } rsp_t;

    typedef struct packed {
        logic accept;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic finish_now;
        logic rsp_free;
    } sts_t;

endpackage

// ===== sv/cpr_ctrl.sv =====
// Controller state machine of the clock page replacer.
module cpr_ctrl
    import cpr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WORK = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall  = 1'b0;
                cmd.accept = req_valid;
                if (req_valid)
                begin
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                // final action waits for room in the output register
                if (sts.finish_now)
                begin
                    if (sts.rsp_free)
                    begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/cpr_datapath.sv =====
// Datapath of the clock page replacer: slot ring, frame map, hand and result register.
module cpr_datapath
    import cpr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    req_t               req_reg;
    logic [SLOTS-1:0]   slot_valid_reg, slot_valid_next;
    logic [SLOTS-1:0]   ref_bit_reg, ref_bit_next;
    logic [FRAMES-1:0]  tracked_reg, tracked_next;
    logic [FRAME_W-1:0] slot_frame_reg [SLOTS];
    logic [SLOT_W-1:0]  frame_slot_reg [FRAMES];
    logic [SLOT_W-1:0]  hand_reg, hand_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic [FRAME_W-1:0] hand_frame;
    logic [SLOT_W-1:0]  hand_inc;
    logic               hand_hit;
    logic               empty;
    logic [FRAME_W-1:0] f;
    logic [SLOT_W-1:0]  f_slot;
    logic               f_tracked;
    logic               free_any;
    logic [SLOT_W-1:0]  free_idx;
    logic               fill_we;

    assign hand_frame = slot_frame_reg[hand_reg];
    assign hand_hit   = slot_valid_reg[hand_reg] && !ref_bit_reg[hand_reg];
    assign hand_inc   = (hand_reg == SLOT_W'(SLOTS - 1)) ? '0 : hand_reg + SLOT_W'(1);
    assign empty      = (count_reg == '0);
    assign f          = req_reg.frame_num;
    assign f_slot     = frame_slot_reg[f];
    assign f_tracked  = tracked_reg[f];

    assign sts.finish_now = (req_reg.mode != MODE_VICTIM) || empty || hand_hit;
    assign sts.rsp_free   = !rsp_valid_reg || !rsp_stall;

    // lowest free slot
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        ref_bit_next    = ref_bit_reg;
        tracked_next    = tracked_reg;
        hand_next       = hand_reg;
        count_next      = count_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;
        fill_we         = 1'b0;

        if (cmd.step)
        begin
            // second chance: referenced slot loses its bit, hand moves on
            ref_bit_next[hand_reg] = 1'b0;
            hand_next = hand_inc;
        end

        if (cmd.finish)
        begin
            rsp_next.found        = 1'b0;
            rsp_next.victim_frame = '0;
            case (req_reg.mode)
                MODE_VICTIM:
                begin
                    if (!empty)
                    begin
                        slot_valid_next[hand_reg] = 1'b0;
                        tracked_next[hand_frame]  = 1'b0;
                        count_next                = count_reg - CNT_W'(1);
                        hand_next                 = hand_inc;
                        rsp_next.found            = 1'b1;
                        rsp_next.victim_frame     = hand_frame;
                    end
                end
                MODE_PIN:
                begin
                    if (f_tracked)
                    begin
                        slot_valid_next[f_slot] = 1'b0;
                        ref_bit_next[f_slot]    = 1'b0;
                        tracked_next[f]         = 1'b0;
                        count_next              = count_reg - CNT_W'(1);
                    end
                end
                MODE_UNPIN:
                begin
                    if (f_tracked)
                    begin
                        ref_bit_next[f_slot] = 1'b1;
                    end
                    else if (free_any)
                    begin
                        slot_valid_next[free_idx] = 1'b1;
                        ref_bit_next[free_idx]    = 1'b1;
                        tracked_next[f]           = 1'b1;
                        count_next                = count_reg + CNT_W'(1);
                        fill_we                   = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
            rsp_next.tracked_count = count_next;
            rsp_valid_next         = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            ref_bit_reg    <= '0;
            tracked_reg    <= '0;
            hand_reg       <= '0;
            count_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            ref_bit_reg    <= ref_bit_next;
            tracked_reg    <= tracked_next;
            hand_reg       <= hand_next;
            count_reg      <= count_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req;
        end
        if (fill_we)
        begin
            slot_frame_reg[free_idx] <= f;
            frame_slot_reg[f]        <= free_idx;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== sv/clock_page_replacer.sv =====
// Top level of the clock page replacer.
// Clock (second-chance) replacer over a ring of SLOTS slots. One request item
// at a time: it is taken in the cycle after the block goes idle, and its
// result item is loaded into the output register by the work state: without
// moving the hand for pin, unpin, unused mode and a victim request with nothing
// tracked, and for a victim after the hand passes over k slots before the one
// it evicts (k up to 2*SLOTS-1), since the hand visits one slot per cycle. A
// new item is taken in the cycle after the result is loaded, even while that
// result still waits under stall; a result that would overwrite an untaken
// one waits. Reset empties the ring at once, with no clearing pass.
`include "clock_page_replacer_defines.svh"

module clock_page_replacer
    import cpr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    cmd_t cmd;
    sts_t sts;

    cpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    cpr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    `CPR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && !req_stall, req_stall, "accepted item did not make the block busy")
    `CPR_ASSERT_NOW(a_no_frame_without_hit, clk, rst_n, rsp_valid && !rsp.found, rsp.victim_frame == '0, "victim frame set without eviction")
    `CPR_ASSERT_NOW(a_count_bound, clk, rst_n, rsp_valid, rsp.tracked_count <= CNT_W'(SLOTS), "tracked count beyond ring size")
    `CPR_ASSERT_NEXT(a_finish_loads_rsp, clk, rst_n, cmd.finish, rsp_valid, "finished item produced no result")

endmodule
